/* sv/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types for the signed shift-subtract divider pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // special-case and sign flags that ride along with each item
    typedef struct packed {
        logic neg;
        logic ovf;
        logic zdiv;
    } t_flags;

    localparam t_flags FLAGS_NONE = '{neg: 1'b0, ovf: 1'b0, zdiv: 1'b0};

endpackage

/* sv/signed_shift_subtract_divider_core.sv */
// ----------------------------------------------------------------------------
// signed_shift_subtract_divider_core
// Pipelined signed restoring divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
// A new division is taken on every clock edge where start is high; busy is
// never raised. Each item passes an input stage (magnitudes and special
// cases), WIDTH restoring stages that each form one quotient bit, and an
// output stage (sign and special cases); every stage is registered and its
// result shows on o_valid after the output stage, one result per cycle at
// full rate. Results are held for one cycle only. A zero divisor
// gives quotient 0 with o_zero_divisor set; the most negative dividend over
// -1 gives the largest positive value with o_overflow_saturated set.
// ----------------------------------------------------------------------------
module signed_shift_subtract_divider_core #(
    parameter int WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [WIDTH-1:0] i_dividend,
    input  logic signed [WIDTH-1:0] i_divisor,
    output logic                    o_valid,
    output logic signed [WIDTH-1:0] o_quotient,
    output logic                    o_overflow_saturated,
    output logic                    o_zero_divisor
);

    logic                 s_valid [WIDTH+1];
    ssd_pkg::t_flags      s_flags [WIDTH+1];
    logic [WIDTH-1:0]     s_rem   [WIDTH+1];
    logic [WIDTH-1:0]     s_nq    [WIDTH+1];
    logic [WIDTH-1:0]     s_den   [WIDTH+1];
    logic [WIDTH-1:0]     quotient_bits;

    assign busy = 1'b0;

    ssd_prep #(.WIDTH(WIDTH)) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start & ~busy),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (s_valid[0]),
        .o_flags    (s_flags[0]),
        .o_rem      (s_rem[0]),
        .o_nq       (s_nq[0]),
        .o_den      (s_den[0])
    );

    for (genvar g = 0; g < WIDTH; g++) begin : g_step
        ssd_stage #(.WIDTH(WIDTH)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .i_flags (s_flags[g]),
            .i_rem   (s_rem[g]),
            .i_nq    (s_nq[g]),
            .i_den   (s_den[g]),
            .o_valid (s_valid[g+1]),
            .o_flags (s_flags[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_nq    (s_nq[g+1]),
            .o_den   (s_den[g+1])
        );
    end

    ssd_post #(.WIDTH(WIDTH)) u_post (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (s_valid[WIDTH]),
        .i_flags              (s_flags[WIDTH]),
        .i_mag                (s_nq[WIDTH]),
        .o_valid              (o_valid),
        .o_quotient           (quotient_bits),
        .o_overflow_saturated (o_overflow_saturated),
        .o_zero_divisor       (o_zero_divisor)
    );

    assign o_quotient = signed'(quotient_bits);

endmodule

/* sv/ssd_prep.sv */
// ----------------------------------------------------------------------------
// ssd_prep
// Input stage: operand magnitudes, quotient sign and special-case detection.
// ----------------------------------------------------------------------------
module ssd_prep #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [WIDTH-1:0]     i_dividend,
    input  logic [WIDTH-1:0]     i_divisor,
    output logic                 o_valid,
    output ssd_pkg::t_flags      o_flags,
    output logic [WIDTH-1:0]     o_rem,
    output logic [WIDTH-1:0]     o_nq,
    output logic [WIDTH-1:0]     o_den
);

    localparam logic [WIDTH-1:0] SMIN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] ONES = {WIDTH{1'b1}};

    logic                 r_valid;
    ssd_pkg::t_flags      r_flags;
    logic [WIDTH-1:0]     r_nq;
    logic [WIDTH-1:0]     r_den;
    ssd_pkg::t_flags      n_flags;
    logic [WIDTH-1:0]     n_nq;
    logic [WIDTH-1:0]     n_den;

    always_comb begin
        n_flags      = ssd_pkg::FLAGS_NONE;
        n_flags.zdiv = (i_divisor == '0);
        n_flags.ovf  = (i_dividend == SMIN) && (i_divisor == ONES);
        n_flags.neg  = i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
        n_nq         = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
        n_den        = i_divisor[WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_nq    <= n_nq;
        r_den   <= n_den;
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = '0;
    assign o_nq    = r_nq;
    assign o_den   = r_den;

endmodule

/* sv/ssd_stage.sv */
// ----------------------------------------------------------------------------
// ssd_stage
// One restoring division step: shifts in one dividend bit, trial-subtracts
// the divisor and shifts one quotient bit into the low end.
// ----------------------------------------------------------------------------
module ssd_stage #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ssd_pkg::t_flags      i_flags,
    input  logic [WIDTH-1:0]     i_rem,
    input  logic [WIDTH-1:0]     i_nq,
    input  logic [WIDTH-1:0]     i_den,
    output logic                 o_valid,
    output ssd_pkg::t_flags      o_flags,
    output logic [WIDTH-1:0]     o_rem,
    output logic [WIDTH-1:0]     o_nq,
    output logic [WIDTH-1:0]     o_den
);

    logic                 r_valid;
    ssd_pkg::t_flags      r_flags;
    logic [WIDTH-1:0]     r_rem;
    logic [WIDTH-1:0]     r_nq;
    logic [WIDTH-1:0]     r_den;
    logic [WIDTH:0]       trial;
    logic [WIDTH:0]       diff;
    logic                 fits;
    logic [WIDTH-1:0]     n_rem;
    logic [WIDTH-1:0]     n_nq;

    always_comb begin
        trial = {i_rem, i_nq[WIDTH-1]};
        diff  = trial - {1'b0, i_den};
        fits  = ~diff[WIDTH];
        n_rem = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        n_nq  = {i_nq[WIDTH-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= i_flags;
        r_rem   <= n_rem;
        r_nq    <= n_nq;
        r_den   <= i_den;
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;

endmodule

/* sv/ssd_post.sv */
// ----------------------------------------------------------------------------
// ssd_post
// Output stage: applies the quotient sign and the special-case results.
// ----------------------------------------------------------------------------
module ssd_post #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ssd_pkg::t_flags      i_flags,
    input  logic [WIDTH-1:0]     i_mag,
    output logic                 o_valid,
    output logic [WIDTH-1:0]     o_quotient,
    output logic                 o_overflow_saturated,
    output logic                 o_zero_divisor
);

    localparam logic [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};

    logic                 r_valid;
    logic [WIDTH-1:0]     r_quotient;
    logic                 r_ovf;
    logic                 r_zdiv;
    logic [WIDTH-1:0]     n_quotient;

    always_comb begin
        if (i_flags.zdiv) begin
            n_quotient = '0;
        end else if (i_flags.ovf) begin
            n_quotient = SMAX;
        end else if (i_flags.neg) begin
            n_quotient = ~i_mag + 1'b1;
        end else begin
            n_quotient = i_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient <= n_quotient;
        r_ovf      <= i_flags.ovf & ~i_flags.zdiv;
        r_zdiv     <= i_flags.zdiv;
    end

    assign o_valid              = r_valid;
    assign o_quotient           = r_quotient;
    assign o_overflow_saturated = r_ovf;
    assign o_zero_divisor       = r_zdiv;

endmodule

/* sv/ssd_checker.sv */
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks for the divider core: latency and special-case results.
// ----------------------------------------------------------------------------
module ssd_checker #(
    parameter int WIDTH = 32
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic signed [WIDTH-1:0] i_dividend,
    input logic signed [WIDTH-1:0] i_divisor,
    input logic                    o_valid,
    input logic signed [WIDTH-1:0] o_quotient,
    input logic                    o_overflow_saturated,
    input logic                    o_zero_divisor
);

    localparam int LAT = WIDTH + 2;
    localparam logic [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};

    // every transfer in comes out as a result on o_valid
    a_latency_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after input transfer");

    a_latency_back : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching input transfer");

    a_zero_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_divisor == '0)) |-> ##LAT
        (o_zero_divisor && !o_overflow_saturated && (o_quotient == '0)))
        else $error("zero divisor result wrong");

    a_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow_saturated) |->
        (!o_zero_divisor && (o_quotient == signed'(SMAX))))
        else $error("saturated result wrong");

endmodule

bind signed_shift_subtract_divider_core ssd_checker #(.WIDTH(WIDTH)) u_ssd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .start                (start),
    .busy                 (busy),
    .i_dividend           (i_dividend),
    .i_divisor            (i_divisor),
    .o_valid              (o_valid),
    .o_quotient           (o_quotient),
    .o_overflow_saturated (o_overflow_saturated),
    .o_zero_divisor       (o_zero_divisor)
);
